// File: rtl/ps2kmc_pkg.sv
// ps2 controller package: request, command and reply codes plus shared types
`timescale 1ns / 1ps
package ps2kmc_pkg;

	// request types
	localparam logic [2:0] REQ_RD_STATUS = 3'd0;
	localparam logic [2:0] REQ_RD_DATA   = 3'd1;
	localparam logic [2:0] REQ_RD_PORTB  = 3'd2;
	localparam logic [2:0] REQ_RD_A20    = 3'd3;
	localparam logic [2:0] REQ_WR_CMD    = 3'd4;
	localparam logic [2:0] REQ_WR_DATA   = 3'd5;
	localparam logic [2:0] REQ_SCANCODE  = 3'd6;

	// controller commands
	localparam logic [7:0] CMD_RD_MODE     = 8'h20;
	localparam logic [7:0] CMD_WR_MODE     = 8'h60;
	localparam logic [7:0] CMD_AUX_LOOP    = 8'hD3;
	localparam logic [7:0] CMD_AUX_SEND    = 8'hD4;
	localparam logic [7:0] CMD_AUX_TEST    = 8'hA9;
	localparam logic [7:0] CMD_AUX_DISABLE = 8'hA7;
	localparam logic [7:0] CMD_AUX_ENABLE  = 8'hA8;
	localparam logic [7:0] CMD_SYS_RESET   = 8'hFE;
	localparam logic [7:0] CMD_SELF_TEST   = 8'hAA;
	localparam logic [7:0] CMD_KBD_TEST    = 8'hAB;

	// mouse device commands
	localparam logic [7:0] MCMD_SCALE11   = 8'hE6;
	localparam logic [7:0] MCMD_SET_RES   = 8'hE8;
	localparam logic [7:0] MCMD_STATUS    = 8'hE9;
	localparam logic [7:0] MCMD_GET_ID    = 8'hF2;
	localparam logic [7:0] MCMD_SET_RATE  = 8'hF3;
	localparam logic [7:0] MCMD_ENABLE    = 8'hF4;
	localparam logic [7:0] MCMD_DISABLE   = 8'hF5;
	localparam logic [7:0] MCMD_DEFAULTS  = 8'hF6;
	localparam logic [7:0] MCMD_RESET     = 8'hFF;

	// keyboard device command that asks for a self-test reply
	localparam logic [7:0] KCMD_RESET     = 8'hFF;

	// reply bytes and fixed values
	localparam logic [7:0] ACK_BYTE       = 8'hFA;
	localparam logic [7:0] SELF_TEST_OK   = 8'h55;
	localparam logic [7:0] BAT_OK         = 8'hAA;
	localparam logic [7:0] PORTB_VALUE    = 8'h20;
	localparam logic [7:0] A20_VALUE      = 8'h02;
	localparam logic [7:0] STATUS_BASE    = 8'h1C;
	localparam logic [7:0] MODE_RESET     = 8'h03;
	localparam logic [7:0] MODE_AUX_OFF   = 8'h20;
	localparam logic [7:0] RES_RESET      = 8'd2;
	localparam logic [7:0] RATE_RESET     = 8'd100;

	// pending controller command waiting for a data byte
	localparam logic [1:0] PEND_NONE     = 2'd0;
	localparam logic [1:0] PEND_MODE     = 2'd1;
	localparam logic [1:0] PEND_AUX_LOOP = 2'd2;
	localparam logic [1:0] PEND_AUX_SEND = 2'd3;

	// queue write issued by the push buffer
	typedef struct packed {
		logic en;
		logic mouse;
	} ps2kmc_wr_t;

	// follow-on bytes handed to the push buffer
	typedef struct packed {
		logic       load;
		logic       mouse;
		logic [1:0] extra;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
	} ps2kmc_push_t;

endpackage

// File: rtl/ps2_keyboard_mouse_controller.sv
// i8042 style keyboard and mouse controller, top level
`timescale 1ns / 1ps
//  channel | signals                                   | role
//  in      | in_valid, in_ready, req_type, write_value | port access or scancode
//  out     | out_valid, out_ready, read_data, kbd_irq, | one result per transaction
//          | aux_irq, reset_request                    |
//
// a result passes through stage 1 and then the separate output register, stage 2; one
// transaction per cycle while the push buffer is idle and no result stalls in stage 1
// a transaction that queues n bytes writes the first at once and holds in_ready low while the
// push buffer writes the n-1 others (the queue ram has one write port), so n is up to four
// reset puts every state and valid register in its power-on value; the keyboard queue
// tracks its write pointer and a wrap flag so slots never written read as zero, no clearing pass
// in_ready stays high while a result waits on out_ready if stage 1 is empty and the push buffer is idle
module ps2_keyboard_mouse_controller import ps2kmc_pkg::*; #(
	parameter int FIFO_DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] req_type,
	input  logic [7:0] write_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       kbd_irq,
	output logic       aux_irq,
	output logic       reset_request
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	// controller state
	logic [PW-1:0] key_rd_q, key_wr_q, mouse_rd_q, mouse_wr_q;
	logic [CW-1:0] key_cnt_q, mouse_cnt_q;
	logic          key_wrap_q;
	logic [7:0]    mode_q, mres_q, mrate_q;
	logic          obf_q, auxd_q, mstream_q, klev_q, mlev_q;
	logic [1:0]    pend_q;

	logic [PW-1:0] key_rd_n, key_wr_n, mouse_rd_n, mouse_wr_n;
	logic [CW-1:0] key_cnt_n, mouse_cnt_n;
	logic          key_wrap_n;
	logic [7:0]    mode_n, mres_n, mrate_n;
	logic          obf_n, auxd_n, mstream_n, klev_n, mlev_n;
	logic [1:0]    pend_n;

	// decode results
	logic [2:0]    k_n, m_n, k_ok, m_ok, p_ok;
	logic [7:0]    k_b0, k_b1, m_b0, m_b1, m_b2, m_b3;
	logic          m_clear, sts_ref, irq_ref;
	logic [7:0]    rd_val;
	logic          rd_ram, rd_mouse, rd_req, rst_req;
	logic [PW-1:0] key_raddr, p_base;
	logic [CW-1:0] k_space, m_space;
	logic          push_mouse, first_we;
	ps2kmc_push_t  pb_load;
	logic [PW-1:0] pb_start;

	// push buffer and rams
	logic          pb_busy;
	ps2kmc_wr_t    pb_wr;
	logic [PW-1:0] pb_addr;
	logic [7:0]    pb_data;
	logic          kram_we, mram_we;
	logic [PW-1:0] kram_waddr, mram_waddr;
	logic [7:0]    kram_wdata, mram_wdata, kram_rdata, mram_rdata;

	// pipeline
	logic          acc, s1_move;
	logic          valid_s1, ram_s1, mouse_s1, kirq_s1, airq_s1, rst_s1;
	logic [7:0]    rd_s1;
	logic          valid_s2, kirq_s2, airq_s2, rst_s2;
	logic [7:0]    rd_s2;

	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [2:0] n);
		logic [PW:0] s;
		s = {1'b0, p} + (PW+1)'(n);
		if (s >= (PW+1)'(FIFO_DEPTH)) begin
			s = s - (PW+1)'(FIFO_DEPTH);
		end
		return s[PW-1:0];
	endfunction

	assign acc = in_valid && in_ready;

	always_comb begin
		key_rd_n    = key_rd_q;
		key_wr_n    = key_wr_q;
		key_cnt_n   = key_cnt_q;
		key_wrap_n  = key_wrap_q;
		mouse_rd_n  = mouse_rd_q;
		mouse_wr_n  = mouse_wr_q;
		mouse_cnt_n = mouse_cnt_q;
		mode_n      = mode_q;
		mres_n      = mres_q;
		mrate_n     = mrate_q;
		obf_n       = obf_q;
		auxd_n      = auxd_q;
		mstream_n   = mstream_q;
		klev_n      = klev_q;
		mlev_n      = mlev_q;
		pend_n      = pend_q;
		k_n         = 3'd0;
		m_n         = 3'd0;
		k_b0        = '0;
		k_b1        = '0;
		m_b0        = '0;
		m_b1        = '0;
		m_b2        = '0;
		m_b3        = '0;
		m_clear     = 1'b0;
		sts_ref     = 1'b0;
		irq_ref     = 1'b0;
		rd_val      = '0;
		rd_ram      = 1'b0;
		rd_mouse    = 1'b0;
		rd_req      = 1'b0;
		rst_req     = 1'b0;
		key_raddr   = key_rd_q;

		unique case (req_type)
			REQ_RD_STATUS: begin
				rd_val = STATUS_BASE | {2'b00, auxd_q, 4'b0000, obf_q};
			end
			REQ_RD_DATA: begin
				rd_req = 1'b1;
				if (key_cnt_q != '0) begin
					rd_ram    = 1'b1;
					key_rd_n  = wrap_add(key_rd_q, 3'd1);
					key_cnt_n = key_cnt_q - CW'(1);
					irq_ref   = 1'b1;
				end else if (mouse_cnt_q != '0) begin
					rd_ram      = 1'b1;
					rd_mouse    = 1'b1;
					mouse_rd_n  = wrap_add(mouse_rd_q, 3'd1);
					mouse_cnt_n = mouse_cnt_q - CW'(1);
					irq_ref     = 1'b1;
				end else begin
					// empty read repeats the previous keyboard slot
					key_raddr = (key_rd_q == '0) ? PW'(FIFO_DEPTH - 1) : key_rd_q - PW'(1);
					// with the queue empty, nothing written yet means zero
					rd_ram    = key_wrap_q || (key_wr_q != '0);
				end
			end
			REQ_RD_PORTB: rd_val = PORTB_VALUE;
			REQ_RD_A20:   rd_val = A20_VALUE;
			REQ_WR_CMD: begin
				unique case (write_value)
					CMD_RD_MODE: begin
						k_n     = 3'd1;
						k_b0    = mode_q;
						irq_ref = 1'b1;
					end
					CMD_WR_MODE:     pend_n = PEND_MODE;
					CMD_AUX_LOOP:    pend_n = PEND_AUX_LOOP;
					CMD_AUX_SEND:    pend_n = PEND_AUX_SEND;
					CMD_AUX_TEST: begin
						m_n     = 3'd1;
						m_b0    = 8'h00;
						irq_ref = 1'b1;
					end
					CMD_AUX_DISABLE: mode_n = mode_q | MODE_AUX_OFF;
					CMD_AUX_ENABLE:  mode_n = mode_q & ~MODE_AUX_OFF;
					CMD_SYS_RESET:   rst_req = 1'b1;
					CMD_SELF_TEST: begin
						k_n     = 3'd1;
						k_b0    = SELF_TEST_OK;
						irq_ref = 1'b1;
					end
					CMD_KBD_TEST: begin
						k_n     = 3'd1;
						k_b0    = 8'h00;
						irq_ref = 1'b1;
					end
					default: ;
				endcase
			end
			REQ_WR_DATA: begin
				pend_n = PEND_NONE;
				case (pend_q)
					PEND_MODE: begin
						mode_n  = write_value;
						irq_ref = 1'b1;
					end
					PEND_AUX_LOOP: begin
						m_n     = 3'd2;
						m_b0    = write_value;
						m_b1    = ACK_BYTE;
						sts_ref = 1'b1;
					end
					PEND_AUX_SEND: begin
						m_n     = 3'd1;
						m_b0    = ACK_BYTE;
						sts_ref = 1'b1;
						case (write_value) inside
							// scaling bit is never set, nothing to clear
							MCMD_SCALE11: ;
							MCMD_SET_RES: mres_n = write_value;
							MCMD_STATUS: begin
								m_n  = 3'd4;
								m_b1 = {2'b00, mstream_q, 5'b00000};
								m_b2 = mres_q;
								m_b3 = mrate_q;
							end
							MCMD_GET_ID: begin
								m_n  = 3'd2;
								m_b1 = 8'h00;
							end
							MCMD_SET_RATE: mrate_n = write_value;
							MCMD_ENABLE:   mstream_n = 1'b1;
							MCMD_DISABLE:  mstream_n = 1'b0;
							MCMD_DEFAULTS, MCMD_RESET: begin
								// the first ack is flushed with the queue
								mstream_n = 1'b0;
								mres_n    = RES_RESET;
								mrate_n   = RATE_RESET;
								m_clear   = 1'b1;
								m_n       = 3'd3;
								m_b1      = BAT_OK;
								m_b2      = 8'h00;
							end
							default: ;
						endcase
					end
					default: begin
						k_n     = 3'd1;
						k_b0    = ACK_BYTE;
						sts_ref = 1'b1;
						if (write_value == KCMD_RESET) begin
							k_n  = 3'd2;
							k_b1 = BAT_OK;
						end
					end
				endcase
			end
			REQ_SCANCODE: begin
				k_n     = 3'd1;
				k_b0    = write_value;
				irq_ref = 1'b1;
			end
			default: ;
		endcase

		if (m_clear) begin
			mouse_rd_n  = '0;
			mouse_wr_n  = '0;
			mouse_cnt_n = '0;
		end

		// full queues drop the extra bytes
		k_space = CW'(FIFO_DEPTH) - key_cnt_n;
		m_space = CW'(FIFO_DEPTH) - mouse_cnt_n;
		k_ok    = (k_space < CW'(k_n)) ? k_space[2:0] : k_n;
		m_ok    = (m_space < CW'(m_n)) ? m_space[2:0] : m_n;

		p_base      = (m_n != 3'd0) ? mouse_wr_n : key_wr_n;
		key_cnt_n   = key_cnt_n + CW'(k_ok);
		key_wr_n    = wrap_add(key_wr_n, k_ok);
		mouse_cnt_n = mouse_cnt_n + CW'(m_ok);
		mouse_wr_n  = wrap_add(mouse_wr_n, m_ok);
		if (k_ok != 3'd0 && key_wr_n <= key_wr_q) begin
			key_wrap_n = 1'b1;
		end

		if (sts_ref || irq_ref) begin
			obf_n  = (key_cnt_n != '0) || (mouse_cnt_n != '0);
			auxd_n = (key_cnt_n == '0) && (mouse_cnt_n != '0);
		end
		if (irq_ref) begin
			klev_n = (key_cnt_n != '0);
			mlev_n = (key_cnt_n == '0) && (mouse_cnt_n != '0);
		end
	end

	// one queue takes pushes per transaction; first byte goes straight to the ram
	assign push_mouse    = (m_n != 3'd0);
	assign p_ok          = push_mouse ? m_ok : k_ok;
	assign first_we      = acc && (p_ok != 3'd0);
	assign pb_start      = wrap_add(p_base, 3'd1);
	assign pb_load.load  = acc && (p_ok > 3'd1);
	assign pb_load.mouse = push_mouse;
	assign pb_load.extra = (p_ok > 3'd1) ? 2'(p_ok - 3'd1) : 2'd0;
	assign pb_load.b1    = push_mouse ? m_b1 : k_b1;
	assign pb_load.b2    = m_b2;
	assign pb_load.b3    = m_b3;

	ps2kmc_push_buf #(
		.DEPTH(FIFO_DEPTH)
	) u_push_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (pb_load),
		.start_addr(pb_start),
		.busy      (pb_busy),
		.wr        (pb_wr),
		.wr_addr   (pb_addr),
		.wr_data   (pb_data)
	);

	assign kram_we    = (first_we && !push_mouse) || (pb_wr.en && !pb_wr.mouse);
	assign kram_waddr = pb_wr.en ? pb_addr : p_base;
	assign kram_wdata = pb_wr.en ? pb_data : k_b0;
	assign mram_we    = (first_we && push_mouse) || (pb_wr.en && pb_wr.mouse);
	assign mram_waddr = pb_wr.en ? pb_addr : p_base;
	assign mram_wdata = pb_wr.en ? pb_data : m_b0;

	ps2kmc_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (kram_we),
		.waddr(kram_waddr),
		.wdata(kram_wdata),
		.re   (acc && rd_req),
		.raddr(key_raddr),
		.rdata(kram_rdata)
	);

	ps2kmc_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_mouse_ram (
		.clk  (clk),
		.we   (mram_we),
		.waddr(mram_waddr),
		.wdata(mram_wdata),
		.re   (acc && rd_req),
		.raddr(mouse_rd_q),
		.rdata(mram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_rd_q    <= '0;
			key_wr_q    <= '0;
			key_cnt_q   <= '0;
			key_wrap_q  <= 1'b0;
			mouse_rd_q  <= '0;
			mouse_wr_q  <= '0;
			mouse_cnt_q <= '0;
			mode_q      <= MODE_RESET;
			mres_q      <= RES_RESET;
			mrate_q     <= RATE_RESET;
			obf_q       <= 1'b0;
			auxd_q      <= 1'b0;
			mstream_q   <= 1'b0;
			klev_q      <= 1'b0;
			mlev_q      <= 1'b0;
			pend_q      <= PEND_NONE;
		end else if (acc) begin
			key_rd_q    <= key_rd_n;
			key_wr_q    <= key_wr_n;
			key_cnt_q   <= key_cnt_n;
			key_wrap_q  <= key_wrap_n;
			mouse_rd_q  <= mouse_rd_n;
			mouse_wr_q  <= mouse_wr_n;
			mouse_cnt_q <= mouse_cnt_n;
			mode_q      <= mode_n;
			mres_q      <= mres_n;
			mrate_q     <= mrate_n;
			obf_q       <= obf_n;
			auxd_q      <= auxd_n;
			mstream_q   <= mstream_n;
			klev_q      <= klev_n;
			mlev_q      <= mlev_n;
			pend_q      <= pend_n;
		end
	end

	// stage 1 waits on the ram read, stage 2 is the output register
	assign s1_move  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !pb_busy && (!valid_s1 || s1_move);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!valid_s1 || s1_move) begin
				valid_s1 <= acc;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1    <= rd_val;
			ram_s1   <= rd_ram;
			mouse_s1 <= rd_mouse;
			kirq_s1  <= klev_n;
			airq_s1  <= mlev_n;
			rst_s1   <= rst_req;
		end
		if (s1_move) begin
			rd_s2   <= ram_s1 ? (mouse_s1 ? mram_rdata : kram_rdata) : rd_s1;
			kirq_s2 <= kirq_s1;
			airq_s2 <= airq_s1;
			rst_s2  <= rst_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign read_data     = rd_s2;
	assign kbd_irq       = kirq_s2;
	assign aux_irq       = airq_s2;
	assign reset_request = rst_s2;

endmodule

// File: rtl/ps2kmc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ps2kmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/ps2kmc_push_buf.sv
// holds the follow-on queue bytes of one transaction and writes one per cycle
`timescale 1ns / 1ps
module ps2kmc_push_buf import ps2kmc_pkg::*; #(
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ps2kmc_push_t             load,
	input  logic [$clog2(DEPTH)-1:0] start_addr,
	output logic                     busy,
	output ps2kmc_wr_t               wr,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [7:0]               wr_data
);

	localparam int PW = $clog2(DEPTH);

	logic [1:0]    cnt_q;
	logic          mouse_q;
	logic [PW-1:0] addr_q;
	logic [7:0]    data_q [3];
	logic [PW:0]   addr_inc;

	// next queue slot, wrapping at the depth
	always_comb begin
		addr_inc = {1'b0, addr_q} + (PW+1)'(1);
		if (addr_inc >= (PW+1)'(DEPTH)) begin
			addr_inc = addr_inc - (PW+1)'(DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			mouse_q <= 1'b0;
		end else if (load.load) begin
			cnt_q   <= load.extra;
			mouse_q <= load.mouse;
		end else if (cnt_q != 2'd0) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load.load) begin
			addr_q    <= start_addr;
			data_q[0] <= load.b1;
			data_q[1] <= load.b2;
			data_q[2] <= load.b3;
		end else if (cnt_q != 2'd0) begin
			addr_q    <= addr_inc[PW-1:0];
			data_q[0] <= data_q[1];
			data_q[1] <= data_q[2];
		end
	end

	assign busy     = (cnt_q != 2'd0);
	assign wr.en    = busy;
	assign wr.mouse = mouse_q;
	assign wr_addr  = addr_q;
	assign wr_data  = data_q[0];

endmodule

// File: rtl/ps2kmc_checker.sv
// port level checks for the ps2 controller, bound to the top level
`timescale 1ns / 1ps
module ps2kmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data,
	input logic       kbd_irq,
	input logic       aux_irq,
	input logic       reset_request
);

	// the mouse line only rises while the keyboard queue is empty
	a_irq_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(kbd_irq && aux_irq))
		else $error("both interrupt lines high in one result");

	// a system reset request comes from a command write, which returns no data
	a_reset_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && reset_request) |-> (read_data == 8'h00))
		else $error("reset request carries read data");

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(read_data) &&
			$stable(kbd_irq) && $stable(aux_irq) && $stable(reset_request)))
		else $error("result changed while stalled");

	// with nothing in flight the input side must be open the following cycle
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !(in_valid && in_ready) && in_ready) |=> in_ready)
		else $error("input closed with the pipeline idle");

endmodule

bind ps2_keyboard_mouse_controller ps2kmc_checker u_checker (.*);

// File: dv/ps2_keyboard_mouse_controller_tb.sv
// testbench for the i8042 style keyboard and mouse controller
`timescale 1ns / 1ps
module ps2_keyboard_mouse_controller_tb import ps2kmc_pkg::*; ();

	localparam int          FIFO_DEPTH      = 128;
	localparam int          CYCLE_LIMIT     = 200000;
	localparam int          IDLE_PCT        = 27;
	localparam logic [2:0]  REQ_UNUSED      = 3'd7;
	localparam logic [7:0]  CMD_KBD_DISABLE = 8'hAD;
	localparam logic [7:0]  CMD_KBD_ENABLE  = 8'hAE;
	localparam logic [7:0]  NO_PENDING      = 8'h00;
	localparam logic [7:0]  STS_OBF         = 8'h01;
	localparam logic [7:0]  STS_AUXDATA     = 8'h20;
	localparam logic [7:0]  AUX_SCALE_BIT   = 8'h10;
	localparam logic [7:0]  AUX_EN_BIT      = 8'h20;

	typedef struct packed {
		logic       drain_first;
		logic [2:0] rq;
		logic [7:0] val;
	} access_t;

	typedef struct packed {
		logic [7:0] data;
		logic       kirq;
		logic       airq;
		logic       rst;
	} reply_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] req_type = '0;
	logic [7:0] write_value = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] read_data;
	logic       kbd_irq;
	logic       aux_irq;
	logic       reset_request;

	ps2_keyboard_mouse_controller #(.FIFO_DEPTH(FIFO_DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .write_value(write_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .kbd_irq(kbd_irq), .aux_irq(aux_irq),
		.reset_request(reset_request)
	);

	access_t access_q[$];
	reply_t  due_replies[$];
	int      sent_cnt = 0;
	int      err_cnt = 0;
	int      cycle_cnt = 0;

	// predicted controller state
	logic [7:0] kbd_mem [FIFO_DEPTH];
	logic [7:0] aux_mem [FIFO_DEPTH];
	int         kbd_rd = 0, kbd_wr = 0, kbd_cnt = 0;
	int         aux_rd = 0, aux_wr = 0, aux_cnt = 0;
	logic [7:0] mode_r = MODE_RESET;
	logic [7:0] status_r = STATUS_BASE;
	logic [7:0] pend_cmd = NO_PENDING;
	logic [7:0] aux_status = '0;
	logic [7:0] aux_res = RES_RESET;
	logic [7:0] aux_rate = RATE_RESET;
	logic       kbd_lvl = 1'b0, aux_lvl = 1'b0;

	initial begin
		for (int i = 0; i < FIFO_DEPTH; i++) begin
			kbd_mem[i] = '0;
			aux_mem[i] = '0;
		end
	end

	function void kbd_push(input logic [7:0] b);
		if (kbd_cnt >= FIFO_DEPTH)
			return;
		kbd_mem[kbd_wr] = b;
		kbd_wr = (kbd_wr + 1) % FIFO_DEPTH;
		kbd_cnt++;
	endfunction

	function void aux_push(input logic [7:0] b);
		if (aux_cnt >= FIFO_DEPTH)
			return;
		aux_mem[aux_wr] = b;
		aux_wr = (aux_wr + 1) % FIFO_DEPTH;
		aux_cnt++;
	endfunction

	function void status_refresh();
		status_r = status_r & ~(STS_OBF | STS_AUXDATA);
		if (kbd_cnt > 0)
			status_r = status_r | STS_OBF;
		else if (aux_cnt > 0)
			status_r = status_r | STS_OBF | STS_AUXDATA;
	endfunction

	function void irq_refresh();
		status_refresh();
		kbd_lvl = (kbd_cnt > 0);
		aux_lvl = (kbd_cnt == 0) && (aux_cnt > 0);
	endfunction

	function void mouse_device_cmd(input logic [7:0] v);
		aux_push(ACK_BYTE);
		case (v)
			MCMD_SCALE11: aux_status = aux_status & ~AUX_SCALE_BIT;
			MCMD_SET_RES: aux_res = v;
			MCMD_STATUS: begin
				aux_push(aux_status);
				aux_push(aux_res);
				aux_push(aux_rate);
			end
			MCMD_GET_ID: aux_push(8'h00);
			MCMD_SET_RATE: aux_rate = v;
			MCMD_ENABLE: aux_status = aux_status | AUX_EN_BIT;
			MCMD_DISABLE: aux_status = aux_status & ~AUX_EN_BIT;
			MCMD_DEFAULTS, MCMD_RESET: begin
				// queue is flushed, so the ack pushed above is lost
				aux_status = '0;
				aux_res = RES_RESET;
				aux_rate = RATE_RESET;
				aux_cnt = 0;
				aux_wr = 0;
				aux_rd = 0;
				aux_push(ACK_BYTE);
				aux_push(BAT_OK);
				aux_push(8'h00);
			end
			default: ;
		endcase
		status_refresh();
	endfunction

	// computes the reply of one transaction and advances the predicted state
	function reply_t i8042_access(input logic [2:0] rq, input logic [7:0] v);
		reply_t r;
		r = '0;
		case (rq)
			REQ_RD_STATUS: r.data = status_r;
			REQ_RD_DATA: begin
				if (kbd_cnt != 0) begin
					r.data = kbd_mem[kbd_rd];
					kbd_rd = (kbd_rd + 1) % FIFO_DEPTH;
					kbd_cnt--;
					irq_refresh();
				end else if (aux_cnt != 0) begin
					r.data = aux_mem[aux_rd];
					aux_rd = (aux_rd + 1) % FIFO_DEPTH;
					aux_cnt--;
					irq_refresh();
				end else begin
					// empty: last keyboard byte again, no state change
					r.data = kbd_mem[(kbd_rd + FIFO_DEPTH - 1) % FIFO_DEPTH];
				end
			end
			REQ_RD_PORTB: r.data = PORTB_VALUE;
			REQ_RD_A20: r.data = A20_VALUE;
			REQ_WR_CMD: begin
				case (v)
					CMD_RD_MODE: begin
						kbd_push(mode_r);
						irq_refresh();
					end
					CMD_WR_MODE, CMD_AUX_LOOP, CMD_AUX_SEND: pend_cmd = v;
					CMD_AUX_TEST: begin
						aux_push(8'h00);
						irq_refresh();
					end
					CMD_AUX_DISABLE: mode_r = mode_r | MODE_AUX_OFF;
					CMD_AUX_ENABLE: mode_r = mode_r & ~MODE_AUX_OFF;
					CMD_SYS_RESET: r.rst = 1'b1;
					CMD_SELF_TEST: begin
						kbd_push(SELF_TEST_OK);
						irq_refresh();
					end
					CMD_KBD_TEST: begin
						kbd_push(8'h00);
						irq_refresh();
					end
					default: ;
				endcase
			end
			REQ_WR_DATA: begin
				case (pend_cmd)
					CMD_WR_MODE: begin
						mode_r = v;
						irq_refresh();
					end
					CMD_AUX_LOOP: begin
						aux_push(v);
						aux_push(ACK_BYTE);
						status_refresh();
					end
					CMD_AUX_SEND: mouse_device_cmd(v);
					NO_PENDING: begin
						kbd_push(ACK_BYTE);
						if (v == KCMD_RESET)
							kbd_push(BAT_OK);
						status_refresh();
					end
					default: ;
				endcase
				pend_cmd = NO_PENDING;
			end
			REQ_SCANCODE: begin
				kbd_push(v);
				irq_refresh();
			end
			default: ;
		endcase
		r.kirq = kbd_lvl;
		r.airq = aux_lvl;
		return r;
	endfunction

	task automatic add(input logic [2:0] rq, input logic [7:0] v);
		access_q.push_back('{drain_first: 1'b0, rq: rq, val: v});
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	// random idling, except in a stretch of transactions with no idling on either side
	function automatic logic roll_idle();
		if (sent_cnt >= 900 && sent_cnt < 1200)
			return 1'b0;
		return ($urandom_range(99) < IDLE_PCT);
	endfunction

	// driver: takes the next access from the queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= '0;
			write_value <= '0;
		end else begin
			if (in_valid && in_ready) begin
				due_replies.push_back(i8042_access(req_type, write_value));
				sent_cnt <= sent_cnt + 1;
			end
			if (!in_valid || in_ready) begin
				if (access_q.size() == 0 || roll_idle() ||
				    (access_q[0].drain_first && (due_replies.size() != 0 || in_valid))) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					req_type <= access_q[0].rq;
					write_value <= access_q[0].val;
					void'(access_q.pop_front());
				end
			end
		end
	end

	// monitor: checks each result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		reply_t got, want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{data: read_data, kirq: kbd_irq, airq: aux_irq, rst: reset_request};
				if (due_replies.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result: data %h kirq %b airq %b rst %b",
							got.data, got.kirq, got.airq, got.rst);
				end else begin
					want = due_replies.pop_front();
					if (got.data !== want.data || got.kirq !== want.kirq ||
					    got.airq !== want.airq || got.rst !== want.rst) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch: data %h/%h kirq %b/%b airq %b/%b rst %b/%b (exp/act)",
								want.data, got.data, want.kirq, got.kirq,
								want.airq, got.airq, want.rst, got.rst);
					end
				end
			end
			out_ready <= !roll_idle();
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int         n, kind;
		logic [7:0] b;
		access_t    a;
		bit         pressed;

		pressed = 1'b0;

		// directed: fixed reads, command set and device commands
		add(REQ_RD_STATUS, 8'h00);
		add(REQ_RD_DATA, 8'hFF);
		add(REQ_RD_PORTB, 8'h00);
		add(REQ_RD_A20, 8'hFF);
		add(REQ_UNUSED, 8'hFF);
		add(REQ_SCANCODE, 8'h00);
		add(REQ_SCANCODE, 8'hFF);
		add(REQ_WR_CMD, CMD_RD_MODE);
		add(REQ_WR_CMD, CMD_SELF_TEST);
		add(REQ_WR_CMD, CMD_KBD_TEST);
		add(REQ_WR_CMD, CMD_AUX_TEST);
		add(REQ_WR_CMD, CMD_AUX_DISABLE);
		add(REQ_WR_CMD, CMD_AUX_ENABLE);
		add(REQ_WR_CMD, CMD_KBD_DISABLE);
		add(REQ_WR_CMD, CMD_KBD_ENABLE);
		add(REQ_WR_CMD, CMD_SYS_RESET);
		add(REQ_WR_CMD, CMD_WR_MODE);
		add(REQ_WR_DATA, 8'hFF);
		add(REQ_WR_DATA, KCMD_RESET);
		add(REQ_WR_CMD, CMD_AUX_LOOP);
		add(REQ_WR_DATA, 8'h5A);
		add(REQ_WR_CMD, CMD_AUX_SEND);
		add(REQ_WR_DATA, MCMD_SET_RES);
		add(REQ_WR_CMD, CMD_AUX_SEND);
		add(REQ_WR_DATA, MCMD_SET_RATE);
		add(REQ_WR_CMD, CMD_AUX_SEND);
		add(REQ_WR_DATA, MCMD_STATUS);
		add(REQ_WR_CMD, CMD_AUX_SEND);
		add(REQ_WR_DATA, MCMD_RESET);

		while (access_q.size() < 1700) begin
			if (!pressed && access_q.size() >= 500) begin
				// overflow both queues, then drain past empty; wait for idle first
				pressed = 1'b1;
				n = access_q.size();
				for (int i = 0; i < 140; i++)
					add(REQ_SCANCODE, 8'($urandom_range(255)));
				a = access_q[n];
				a.drain_first = 1'b1;
				access_q[n] = a;
				for (int i = 0; i < 150; i++)
					add(REQ_RD_DATA, 8'($urandom_range(255)));
				for (int i = 0; i < 40; i++) begin
					add(REQ_WR_CMD, CMD_AUX_SEND);
					add(REQ_WR_DATA, MCMD_STATUS);
				end
				for (int i = 0; i < 180; i++)
					add(REQ_RD_DATA, 8'($urandom_range(255)));
			end
			kind = $urandom_range(99);
			if (kind < 20) begin
				n = $urandom_range(1, 24);
				for (int i = 0; i < n; i++)
					add(REQ_SCANCODE, 8'($urandom_range(255)));
			end else if (kind < 40) begin
				n = $urandom_range(1, 24);
				for (int i = 0; i < n; i++)
					add(REQ_RD_DATA, 8'($urandom_range(255)));
			end else if (kind < 52) begin
				case ($urandom_range(10))
					0: b = MCMD_SCALE11;
					1: b = MCMD_SET_RES;
					2: b = MCMD_STATUS;
					3: b = MCMD_GET_ID;
					4: b = MCMD_SET_RATE;
					5: b = MCMD_ENABLE;
					6: b = MCMD_DISABLE;
					7: b = MCMD_DEFAULTS;
					8: b = MCMD_RESET;
					default: b = 8'($urandom_range(255));
				endcase
				add(REQ_WR_CMD, CMD_AUX_SEND);
				add(REQ_WR_DATA, b);
			end else if (kind < 62) begin
				case ($urandom_range(13))
					0: b = CMD_RD_MODE;
					1: b = CMD_WR_MODE;
					2: b = CMD_AUX_LOOP;
					3: b = CMD_AUX_SEND;
					4: b = CMD_AUX_TEST;
					5: b = CMD_AUX_DISABLE;
					6: b = CMD_AUX_ENABLE;
					7: b = CMD_SYS_RESET;
					8: b = CMD_SELF_TEST;
					9: b = CMD_KBD_TEST;
					10: b = CMD_KBD_DISABLE;
					11: b = CMD_KBD_ENABLE;
					default: b = 8'($urandom_range(255));
				endcase
				add(REQ_WR_CMD, b);
				// commands that take a data byte usually get one
				if ((b == CMD_WR_MODE || b == CMD_AUX_LOOP || b == CMD_AUX_SEND) &&
				    $urandom_range(3) != 0)
					add(REQ_WR_DATA, 8'($urandom_range(255)));
			end else if (kind < 68) begin
				add(REQ_WR_DATA, ($urandom_range(2) == 0) ? KCMD_RESET
					: 8'($urandom_range(255)));
			end else if (kind < 76) begin
				add(REQ_WR_CMD, CMD_AUX_LOOP);
				add(REQ_WR_DATA, 8'($urandom_range(255)));
			end else if (kind < 84) begin
				add(3'($urandom_range(3)), 8'($urandom_range(255)));
			end else if (kind < 90) begin
				add(REQ_WR_CMD, CMD_WR_MODE);
				add(REQ_WR_DATA, 8'($urandom_range(255)));
			end else begin
				add(3'($urandom_range(7)), 8'($urandom_range(255)));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (access_q.size() != 0 || in_valid)
			@(posedge clk);
		while (due_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
